>>> rtl/packed_cuckoo_filter_lookup_macros.svh
// Assertion macros for the packed cuckoo filter lookup.
`ifndef PACKED_CUCKOO_FILTER_LOOKUP_MACROS_SVH
`define PACKED_CUCKOO_FILTER_LOOKUP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcf_pkg.sv
// Shared types and constants of the packed cuckoo filter lookup.
package pcf_pkg;

  // Entry geometry
  localparam int FP_BITS     = 27;
  localparam int BUCKET_WAYS = 4;
  localparam int BUCKET_BITS = FP_BITS * BUCKET_WAYS;
  localparam int SLOTS       = 2 * BUCKET_WAYS;

  // Fingerprint modulus, one below the 27-bit mask
  localparam logic [FP_BITS-1:0] FP_MOD = 27'h7FFFFFE;

  // Number of fold steps that bring a 64-bit hash below 2^27
  localparam logic [2:0] FOLD_STEPS = 3'd4;

  // Reset value of the bucket count register
  localparam logic [12:0] BCNT_RST = 13'd4096;

  // Item kinds carried in tuser
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One table byte write
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } wr_req_t;

  // Fingerprint unit status
  typedef struct packed {
    logic               done;
    logic [FP_BITS-1:0] fp;
  } fp_stat_t;

endpackage

>>> rtl/packed_cuckoo_filter_lookup.sv
// Packed cuckoo filter lookup: top level with sequencer and result register.
//
// A write beat (tuser 0) stores one table byte and gives no result. A lookup
// beat (tuser 1) holds off further beats until its result is loaded: eight
// entries are read one per cycle from the two-bank table memory, then the
// read pipe drains (ST_DRAIN) and ST_DONE compares all eight against the
// fingerprint. The fingerprint reduction runs alongside the reads. A finished
// result waits in the output register while the next beat is taken. The
// table needs no clearing pass; a byte must be written before it is looked up.
`include "packed_cuckoo_filter_lookup_macros.svh"

module packed_cuckoo_filter_lookup
  import pcf_pkg::*;
#(
  parameter int MAX_BUCKETS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // cfg: bucket_count
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // byte_addr[15:0], byte_data[23:16], item_hash[87:24], alt_hash[151:88]
  input  logic [151:0] s_axis_tdata,
  // kind[0]
  input  logic         s_axis_tuser,
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], fingerprint[27:1], zero[31:28]
  output logic [31:0]  m_axis_tdata
);

  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int BIT_W = BW + 2 + 5;
  localparam int DEPTH = (MAX_BUCKETS * BUCKET_BITS + 7) / 8;
  localparam int WORDS = DEPTH / 8 + 2;
  localparam int ROWS  = (WORDS + 1) / 2;
  localparam int WW    = $clog2(ROWS) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] SLOT_LAST = 3'(SLOTS - 1);

  logic [1:0]          state_q, state_d;
  logic [2:0]          rd_cnt_q, rd_cnt_d;
  logic [12:0]         bcnt_q;
  logic [BW-1:0]       i1_q, i2_q;
  logic                ok1_q, ok2_q;
  logic                pipe_vld_q;
  logic [2:0]          pipe_slot_q;
  logic [5:0]          pipe_sh_q;
  logic                pipe_ok_q;
  logic [FP_BITS-1:0]  ent_q [SLOTS];
  logic                out_valid_q, out_valid_d;
  logic                out_found_q;
  logic [FP_BITS-1:0]  out_fp_q;

  logic                s_acc, lookup_acc, out_load, hit;
  wr_req_t             wr_req;
  fp_stat_t            fp_stat;
  logic [63:0]         h1, h2, mask, i1, i2;
  logic [BW-1:0]       bkt;
  logic                bkt_ok;
  logic [BW+1:0]       ent_idx;
  logic [BIT_W-1:0]    bitpos;
  logic [WW-1:0]       rd_word;
  logic                rd_en;
  logic [127:0]        window, shifted;
  logic [FP_BITS-1:0]  ext;

  // input beat decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign lookup_acc    = s_acc && (s_axis_tuser == KIND_LOOKUP);
  assign h1            = s_axis_tdata[87:24];
  assign h2            = s_axis_tdata[151:88];

  always_comb begin
    wr_req.en   = s_acc && (s_axis_tuser == KIND_WRITE);
    wr_req.addr = s_axis_tdata[15:0];
    wr_req.data = s_axis_tdata[23:16];
  end

  // bucket indices; a zero count gives an all-ones mask
  always_comb begin
    mask = (bcnt_q == 13'd0) ? '1 : 64'(bcnt_q - 13'd1);
    i1   = h1 & mask;
    i2   = (i1 ^ h2) & mask;
  end

  // entry address for the current read slot
  always_comb begin
    bkt     = rd_cnt_q[2] ? i2_q : i1_q;
    bkt_ok  = rd_cnt_q[2] ? ok2_q : ok1_q;
    ent_idx = {bkt, rd_cnt_q[1:0]};
    bitpos  = BIT_W'(ent_idx) * BIT_W'(FP_BITS);
    rd_word = WW'(bitpos >> 6);
    rd_en   = (state_q == ST_READ);
  end

  pcf_fp_mod u_fp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lookup_acc),
    .hash_i  (h1),
    .stat_o  (fp_stat)
  );

  pcf_table #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_en_i   (rd_en),
    .rd_word_i (rd_word),
    .window_o  (window)
  );

  // entry extraction, MSB-first from the window
  always_comb begin
    shifted = window << pipe_sh_q;
    ext     = shifted[127:101];
  end

  // compare all eight entries against the fingerprint
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      hit = hit | (ent_q[k] == fp_stat.fp);
    end
  end

  assign out_load = (state_q == ST_DONE) && fp_stat.done &&
                    (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (lookup_acc) begin
          state_d  = ST_READ;
          rd_cnt_d = '0;
        end
      end
      ST_READ: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == SLOT_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result beat handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      bcnt_q      <= BCNT_RST;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      pipe_vld_q  <= rd_en;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bcnt_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (lookup_acc) begin
      i1_q  <= BW'(i1);
      i2_q  <= BW'(i2);
      ok1_q <= (i1 < 64'(MAX_BUCKETS));
      ok2_q <= (i2 < 64'(MAX_BUCKETS));
    end
    pipe_slot_q <= rd_cnt_q;
    pipe_sh_q   <= bitpos[5:0];
    pipe_ok_q   <= bkt_ok;
    // out-of-range buckets read as zero and never match
    if (pipe_vld_q) begin
      ent_q[pipe_slot_q] <= pipe_ok_q ? ext : '0;
    end
    if (out_load) begin
      out_found_q <= hit;
      out_fp_q    <= fp_stat.fp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_fp_q, out_found_q};

  // checks
  `PCF_ASSERT_NEXT(a_lookup_starts_read, lookup_acc, (state_q == ST_READ) && (rd_cnt_q == 3'd0), "lookup beat did not start the read sweep")
  `PCF_ASSERT_NOW(a_fp_ready_at_done, state_q == ST_DONE, fp_stat.done, "fingerprint not ready at compare")
  `PCF_ASSERT_NOW(a_pipe_in_sweep, pipe_vld_q, (state_q == ST_READ) || (state_q == ST_DRAIN), "read pipe busy outside the sweep")

endmodule

>>> rtl/pcf_fp_mod.sv
// Fingerprint unit: (hash mod 0x7FFFFFE) + 1 by iterative folding.
module pcf_fp_mod
  import pcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] hash_i,
  output fp_stat_t    stat_o
);

  logic [63:0]        v_q, v_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [FP_BITS-1:0] fp_q, fp_d;
  logic [38:0]        fold_sum;
  logic [FP_BITS-1:0] red;

  // 2^27 == 2 mod M, so hi * 2^27 + lo folds to hi * 2 + lo
  always_comb begin
    fold_sum = {1'b0, v_q[63:27], 1'b0} + 39'(v_q[26:0]);
    red      = (v_q[26:0] >= FP_MOD) ? (v_q[26:0] - FP_MOD) : v_q[26:0];
  end

  always_comb begin
    v_d    = v_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    fp_d   = fp_q;
    if (start_i) begin
      v_d    = hash_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (cnt_q == FOLD_STEPS) begin
        // final compare-subtract, then offset by one
        fp_d   = red + 27'd1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        v_d   = 64'(fold_sum);
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    fp_q <= fp_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.fp   = fp_q;

endmodule

>>> rtl/pcf_table.sv
// Filter table: two banks of 8-byte words, byte writes, 16-byte window reads.
module pcf_table
  import pcf_pkg::*;
#(
  parameter int MAX_BUCKETS = 4096,
  localparam int DEPTH = (MAX_BUCKETS * BUCKET_BITS + 7) / 8,
  localparam int WORDS = DEPTH / 8 + 2,
  localparam int ROWS  = (WORDS + 1) / 2,
  localparam int RW    = $clog2(ROWS),
  localparam int WW    = RW + 1
) (
  input  logic          clk_i,
  input  wr_req_t       wr_i,
  input  logic          rd_en_i,
  input  logic [WW-1:0] rd_word_i,
  output logic [127:0]  window_o
);

  // even words in bank 0, odd words in bank 1; lowest address in the top byte
  logic [63:0]   bank0 [ROWS];
  logic [63:0]   bank1 [ROWS];
  logic [63:0]   rd0_q, rd1_q;
  logic          odd_q;
  logic          wr_ok;
  logic [RW-1:0] wr_row;
  logic [RW-1:0] rd_row_lo, rd_row0;

  always_comb begin
    wr_ok     = wr_i.en && (32'(wr_i.addr) < 32'(DEPTH));
    wr_row    = RW'(wr_i.addr[15:4]);
    rd_row_lo = rd_word_i[WW-1:1];
    rd_row0   = rd_word_i[0] ? (rd_row_lo + RW'(1)) : rd_row_lo;
  end

  // bank 0
  always_ff @(posedge clk_i) begin
    if (wr_ok && !wr_i.addr[3]) begin
      bank0[wr_row][{~wr_i.addr[2:0], 3'b000} +: 8] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd0_q <= bank0[rd_row0];
    end
  end

  // bank 1
  always_ff @(posedge clk_i) begin
    if (wr_ok && wr_i.addr[3]) begin
      bank1[wr_row][{~wr_i.addr[2:0], 3'b000} +: 8] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd1_q <= bank1[rd_row_lo];
      odd_q <= rd_word_i[0];
    end
  end

  // word w first, then word w+1
  assign window_o = odd_q ? {rd1_q, rd0_q} : {rd0_q, rd1_q};

endmodule
